/* src/dmm_pkg.sv */
// dmm_pkg: shared types and codes for the dense matrix multiply core.
// No dependencies; used by dmm_cell and dense_matrix_multiply_core.
`default_nettype none
package dmm_pkg;

  localparam int IDX_W  = 3;   // row/column field width
  localparam int ELEM_W = 16;  // Q8.8 element
  localparam int PROD_W = 35;  // Q19.16 dot product
  localparam int DIM_W  = 4;   // dimension register width

  typedef enum logic [1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_FLUSH,
    ST_DRAIN
  } state_t;

  // A operand travelling up the cell chain
  typedef struct packed {
    logic                     valid;
    logic                     first;
    logic [IDX_W-1:0]         k;
    logic signed [ELEM_W-1:0] a;
  } feed_t;

  // B element write, broadcast to all cells
  typedef struct packed {
    logic                     en;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] data;
  } bwr_t;

  // result chain control
  typedef struct packed {
    logic capture;
    logic shift;
  } rctl_t;

endpackage
`default_nettype wire

/* src/dense_matrix_multiply_core.sv */
// dense_matrix_multiply_core: top level, sequencer, A store and cell chain.
// Depends on dmm_pkg and dmm_cell.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tuser mode, s_tdata row/col/value
//  m_*     | out | m_tvalid/m_tready  | m_tdata row/col/product, m_tlast
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_wdata
//
// Per result row, a compute request runs a feed phase over inner_dim A
// elements, a flush through the cell chain and a drain of cols_b results
// (one per output transfer, held under m_tready stalls). The chain has
// MAX_DIM cells, one per result column; A is read from a memory with
// separate write and read ports, one element a cycle. Reset is synchronous,
// active high, clears control state and presets the dimensions to 8; stores
// are undefined until loaded. s_tready is low while a compute request is in progress.
`default_nettype none
module dense_matrix_multiply_core #(
  parameter int MAX_DIM = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // row_index[2:0], col_index[5:3], element_value[21:6]
  input  wire logic [1:0]  s_tuser,   // mode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // out_row[2:0], out_col[5:3], product_value[40:6]
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_wdata
);

  localparam int LW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = dmm_pkg::DIM_W;
  localparam int FW    = $clog2(MAX_DIM + 2);

  // configuration
  logic [DW-1:0] rows_a, inner_dim, cols_b;
  logic [DW-1:0] nr, nk, nc;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DW'(8);
      inner_dim <= DW'(8);
      cols_b    <= DW'(8);
    end else if (cfg_we) begin
      unique case (dmm_pkg::cfg_idx_t'(cfg_index))
        dmm_pkg::CFG_ROWS_A:    rows_a    <= cfg_wdata;
        dmm_pkg::CFG_INNER_DIM: inner_dim <= cfg_wdata;
        dmm_pkg::CFG_COLS_B:    cols_b    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to MAX_DIM
  function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) r = DW'(1);
    else if (v > DW'(MAX_DIM)) r = DW'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  always_comb begin
    nr = eff_dim(rows_a);
    nk = eff_dim(inner_dim);
    nc = eff_dim(cols_b);
  end

  // input decode
  dmm_pkg::mode_t mode;
  logic [2:0]  in_row, in_col;
  logic signed [15:0] in_val;
  logic in_acc, idx_ok;

  assign mode   = dmm_pkg::mode_t'(s_tuser);
  assign in_row = s_tdata[2:0];
  assign in_col = s_tdata[5:3];
  assign in_val = s_tdata[21:6];
  assign in_acc = s_tvalid && s_tready;
  assign idx_ok = (in_row < 3'(MAX_DIM)) && (in_col < 3'(MAX_DIM))
                || (MAX_DIM >= 8);

  // sequencer
  dmm_pkg::state_t state, state_next;
  logic [LW-1:0] ri, ri_next, cj, cj_next, kl, kl_next;
  logic [FW-1:0] fcnt, fcnt_next;
  logic issue, capture, drain;
  logic slot_free;

  assign slot_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmm_pkg::ST_IDLE;
      ri    <= '0;
      cj    <= '0;
      kl    <= '0;
      fcnt  <= '0;
    end else begin
      state <= state_next;
      ri    <= ri_next;
      cj    <= cj_next;
      kl    <= kl_next;
      fcnt  <= fcnt_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    ri_next    = ri;
    cj_next    = cj;
    kl_next    = kl;
    fcnt_next  = fcnt;
    unique case (state)
      dmm_pkg::ST_IDLE: begin
        if (in_acc && mode == dmm_pkg::MODE_COMPUTE) begin
          state_next = dmm_pkg::ST_FEED;
          ri_next    = '0;
          kl_next    = '0;
        end
      end
      dmm_pkg::ST_FEED: begin
        if (DW'(kl) == nk - DW'(1)) begin
          state_next = dmm_pkg::ST_FLUSH;
          fcnt_next  = '0;
        end else begin
          kl_next = kl + LW'(1);
        end
      end
      dmm_pkg::ST_FLUSH: begin
        if (fcnt == FW'(MAX_DIM)) begin
          state_next = dmm_pkg::ST_DRAIN;
          cj_next    = '0;
        end else begin
          fcnt_next = fcnt + FW'(1);
        end
      end
      dmm_pkg::ST_DRAIN: begin
        if (slot_free) begin
          if (DW'(cj) == nc - DW'(1)) begin
            if (DW'(ri) == nr - DW'(1)) begin
              state_next = dmm_pkg::ST_IDLE;
            end else begin
              state_next = dmm_pkg::ST_FEED;
              ri_next    = ri + LW'(1);
              kl_next    = '0;
            end
          end else begin
            cj_next = cj + LW'(1);
          end
        end
      end
      default: state_next = dmm_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready = 1'b0;
    issue    = 1'b0;
    capture  = 1'b0;
    drain    = 1'b0;
    unique case (state)
      dmm_pkg::ST_IDLE:  s_tready = 1'b1;
      dmm_pkg::ST_FEED:  issue    = 1'b1;
      dmm_pkg::ST_FLUSH: capture  = (fcnt == FW'(MAX_DIM));
      dmm_pkg::ST_DRAIN: drain    = slot_free;
      default: ;
    endcase
  end

  // A store, registered read
  logic signed [15:0] mem_a [DEPTH];
  logic signed [15:0] a_rd;
  logic [AW-1:0] wr_addr, rd_addr;

  assign wr_addr = AW'(in_row[LW-1:0] * MAX_DIM + in_col[LW-1:0]);
  assign rd_addr = AW'(ri * MAX_DIM + kl);

  always_ff @(posedge clk) begin
    if (in_acc && mode == dmm_pkg::MODE_LOAD_A && idx_ok) begin
      mem_a[wr_addr] <= in_val;
    end
    a_rd <= mem_a[rd_addr];
  end

  // feed stage aligned with the memory read
  dmm_pkg::feed_t feed0;
  logic           feed_v;
  logic           feed_first;
  logic [LW-1:0]  feed_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_v <= 1'b0;
    end else begin
      feed_v <= issue;
    end
    feed_first <= (kl == '0);
    feed_k     <= kl;
  end

  always_comb begin
    feed0.valid = feed_v;
    feed0.first = feed_first;
    feed0.k     = dmm_pkg::IDX_W'(feed_k);
    feed0.a     = a_rd;
  end

  dmm_pkg::bwr_t bwr;
  always_comb begin
    bwr.en   = in_acc && mode == dmm_pkg::MODE_LOAD_B && idx_ok;
    bwr.row  = in_row;
    bwr.col  = in_col;
    bwr.data = in_val;
  end

  dmm_pkg::rctl_t rctl;
  assign rctl.capture = capture;
  assign rctl.shift   = drain;

  // cell chain: A flows up, results shift down to cell 0
  dmm_pkg::feed_t feed_c [MAX_DIM+1];
  logic signed [dmm_pkg::PROD_W-1:0] res_c [MAX_DIM+1];

  assign feed_c[0]      = feed0;
  assign res_c[MAX_DIM] = '0;

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    dmm_cell #(
      .MAX_DIM (MAX_DIM),
      .COL     (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .feed_in  (feed_c[g]),
      .feed_out (feed_c[g+1]),
      .bwr      (bwr),
      .rctl     (rctl),
      .res_in   (res_c[g+1]),
      .res_out  (res_c[g])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (drain) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (drain) begin
      m_tdata <= {7'd0, res_c[0], 3'(cj), 3'(ri)};
      m_tlast <= (DW'(cj) == nc - DW'(1)) && (DW'(ri) == nr - DW'(1));
    end
  end

endmodule
`default_nettype wire

/* src/dmm_cell.sv */
// dmm_cell: one output column. Holds column COL of B, accumulates A*B,
// forwards the A operand to its neighbor and shifts results toward cell 0.
// Depends on dmm_pkg.
`default_nettype none
module dmm_cell #(
  parameter int MAX_DIM = 8,
  parameter int COL     = 0
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire dmm_pkg::feed_t                    feed_in,
  output dmm_pkg::feed_t                         feed_out,
  input  wire dmm_pkg::bwr_t                     bwr,
  input  wire dmm_pkg::rctl_t                    rctl,
  input  wire logic signed [dmm_pkg::PROD_W-1:0] res_in,
  output logic signed [dmm_pkg::PROD_W-1:0]      res_out
);

  localparam int LW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic signed [dmm_pkg::ELEM_W-1:0] bcol [MAX_DIM];
  logic signed [dmm_pkg::PROD_W-1:0] acc;
  logic signed [dmm_pkg::PROD_W-1:0] acc_next;
  logic signed [2*dmm_pkg::ELEM_W-1:0] prod;
  logic signed [dmm_pkg::PROD_W-1:0] res;

  always_ff @(posedge clk) begin
    if (bwr.en && (bwr.col == dmm_pkg::IDX_W'(COL))) begin
      bcol[bwr.row[LW-1:0]] <= bwr.data;
    end
  end

  always_comb begin
    prod     = feed_in.a * bcol[feed_in.k[LW-1:0]];
    acc_next = (feed_in.first ? '0 : acc)
             + {{(dmm_pkg::PROD_W-2*dmm_pkg::ELEM_W){prod[2*dmm_pkg::ELEM_W-1]}}, prod};
  end

  always_ff @(posedge clk) begin
    if (feed_in.valid) begin
      acc <= acc_next;
    end
    if (rctl.capture) begin
      res <= acc;
    end else if (rctl.shift) begin
      res <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_out.valid <= 1'b0;
    end else begin
      feed_out.valid <= feed_in.valid;
    end
    feed_out.first <= feed_in.first;
    feed_out.k     <= feed_in.k;
    feed_out.a     <= feed_in.a;
  end

  assign res_out = res;

endmodule
`default_nettype wire

/* src/dmm_checker.sv */
// dmm_checker: port-level assertions for dense_matrix_multiply_core.
// Bound to the top level below; depends on dmm_pkg for the mode codes.
`default_nettype none
module dmm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic        m_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // a compute request blocks further input
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == dmm_pkg::MODE_COMPUTE |=> !s_tready)
    else $error("input accepted right after compute request");

  // mid-product results only appear while busy
  a_mid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("ready while product still draining");

  // reset empties the output
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind dense_matrix_multiply_core dmm_checker u_dmm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire
